>>> src/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg: shared types and constants of the 3x3 median filter
// pixel and window column types, register codes and small compare helpers
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int PIX_W        = 8;
    localparam int FW_W         = 11;    // frame_width register
    localparam int FH_W         = 13;    // frame_height register, also row counter
    localparam int ITEMS_W      = 23;    // items taken in the current frame
    localparam int HEIGHT_LIMIT = 4096;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    localparam logic [FW_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [FH_W-1:0] RESET_HEIGHT = 13'd480;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef logic [PIX_W-1:0] t_pixel;

    // one window column: raw pixels and the same three sorted
    typedef struct packed {
        t_pixel top;
        t_pixel cen;
        t_pixel bot;
        t_pixel lo;
        t_pixel md;
        t_pixel hi;
    } t_column;

    function automatic t_pixel min2(input t_pixel a, input t_pixel b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pixel max2(input t_pixel a, input t_pixel b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_pixel min3(input t_pixel a, input t_pixel b, input t_pixel c);
        return min2(min2(a, b), c);
    endfunction

    function automatic t_pixel max3(input t_pixel a, input t_pixel b, input t_pixel c);
        return max2(max2(a, b), c);
    endfunction

    function automatic t_pixel med3(input t_pixel a, input t_pixel b, input t_pixel c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // build a column from top, center and bottom pixels
    function automatic t_column make_column(input t_pixel a, input t_pixel b,
                                            input t_pixel c);
        t_column col;
        col.top = a;
        col.cen = b;
        col.bot = c;
        col.lo  = min3(a, b, c);
        col.md  = med3(a, b, c);
        col.hi  = max3(a, b, c);
        return col;
    endfunction

endpackage

>>> src/mf3_if.sv
// ----------------------------------------------------------------------------
// mf3 channel interfaces
// valid/ready channels for input items, result items and register writes
// ----------------------------------------------------------------------------
interface mf3_pix_in_if;
    logic            valid;
    logic            ready;
    logic            kind;
    mf3_pkg::t_pixel pixel_in;

    modport source (output valid, output kind, output pixel_in, input ready);
    modport sink   (input valid, input kind, input pixel_in, output ready);
endinterface

interface mf3_pix_out_if;
    logic            valid;
    logic            ready;
    mf3_pkg::t_pixel pixel_out;
    logic            frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface mf3_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mf3_pkg::CFG_IDX_W-1:0]    index;
    logic [mf3_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram: generic simple dual-port RAM
// one write port, one read port with registered read data (read before write)
// ----------------------------------------------------------------------------
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/mf3_col_cell.sv
// ----------------------------------------------------------------------------
// mf3_col_cell: one column cell of the window chain
// holds a raw and sorted column, takes the neighbor's column on shift
// ----------------------------------------------------------------------------
module mf3_col_cell (
    input  logic             i_clk,
    input  logic             i_shift,
    input  mf3_pkg::t_column i_col,
    output mf3_pkg::t_column o_col
);

    mf3_pkg::t_column r_col;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

>>> src/mf3_median.sv
// ----------------------------------------------------------------------------
// mf3_median: median of nine from three sorted columns
// max of lows, median of mids, min of highs, then median of those three
// ----------------------------------------------------------------------------
module mf3_median (
    input  mf3_pkg::t_column i_c0,
    input  mf3_pkg::t_column i_c1,
    input  mf3_pkg::t_column i_c2,
    output mf3_pkg::t_pixel  o_median
);

    mf3_pkg::t_pixel lo_max;
    mf3_pkg::t_pixel md_med;
    mf3_pkg::t_pixel hi_min;

    always_comb begin
        lo_max   = mf3_pkg::max3(i_c0.lo, i_c1.lo, i_c2.lo);
        md_med   = mf3_pkg::med3(i_c0.md, i_c1.md, i_c2.md);
        hi_min   = mf3_pkg::min3(i_c0.hi, i_c1.hi, i_c2.hi);
        o_median = mf3_pkg::med3(lo_max, md_med, hi_min);
    end

endmodule

>>> src/median3x3_filter_stream.sv
// ----------------------------------------------------------------------------
// median3x3_filter_stream: streaming 3x3 median filter
// raster-order 8-bit pixels in, median-filtered pixels out, borders passed
// ----------------------------------------------------------------------------
// The block takes one item per clock unless stalled and gives at most one
// result per item. Each item (pixel, or flush counted as pixel value 0) takes
// the next stream position; a result appears once frame_width+1 items of the
// frame are in, so after the frame the host sends frame_width+1 flush items,
// and the last of them brings the result marked frame_last, after which a new
// frame begins. Interior pixels get the median of their 3x3 neighborhood;
// pixels of the first and last row and column pass through. Without stalls
// the sustained rate is one item per cycle, set by the two line buffer RAMs
// (one read and one write each per item) and the column cell chain shifting
// once per item. An item passes stage 1 and stage 2 into the output register.
// A register write restarts the frame and holds off input items while the
// end-of-frame count is recomputed; line buffers keep their data.
// ----------------------------------------------------------------------------
module median3x3_filter_stream #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mf3_cfg_if.sink              i_cfg,
    mf3_pix_in_if.sink           i_pix,
    mf3_pix_out_if.source        o_pix
);

    localparam int AW  = $clog2(MAX_WIDTH);        // line buffer address
    localparam int WW  = $clog2(MAX_WIDTH + 1);    // effective width
    localparam int LTW = WW + mf3_pkg::FH_W + 1;   // end-of-frame item count

    // configuration registers
    logic [mf3_pkg::FW_W-1:0] r_frame_width;
    logic [mf3_pkg::FH_W-1:0] r_frame_height;
    logic                     r_cfg_busy;
    logic                     cfg_write;

    // effective sizes and end-of-frame count
    logic [WW-1:0]            eff_w;
    logic [mf3_pkg::FH_W-1:0] eff_h;
    logic [LTW-1:0]           n_last_t;
    logic [LTW-1:0]           r_last_t;

    // stream position
    logic [AW-1:0]               r_col;
    logic [mf3_pkg::FH_W-1:0]    r_row;
    logic [mf3_pkg::ITEMS_W-1:0] r_items;

    // accept stage decisions
    logic            in_accept;
    logic            in_ready;
    logic            produce;
    logic            last;
    logic            wrap;
    logic            med_sel;
    mf3_pkg::t_pixel px;

    // stage 1: waiting for line buffer read data
    logic            r_s1_valid;
    mf3_pkg::t_pixel r_s1_px;
    logic [AW-1:0]   r_s1_addr;
    logic            r_s1_med;
    logic            r_s1_last;
    logic            r_s1_prod;
    logic            r_fwd;
    mf3_pkg::t_pixel r_fwd_up;
    mf3_pkg::t_pixel r_fwd_mid;
    logic            s1_commit;
    mf3_pkg::t_pixel up_rd;
    mf3_pkg::t_pixel mid_rd;
    mf3_pkg::t_pixel up;
    mf3_pkg::t_pixel mid;

    // stage 2: window cells hold the neighborhood of this result
    logic            r_s2_valid;
    logic            r_s2_med;
    logic            r_s2_last;
    logic            s2_ready;

    // output register
    logic            r_out_valid;
    mf3_pkg::t_pixel r_out_pixel;
    logic            r_out_last;
    logic            out_ready;

    // window chain
    mf3_pkg::t_column new_col;
    mf3_pkg::t_column cell_in  [3];
    mf3_pkg::t_column cell_out [3];
    mf3_pkg::t_pixel  median;

    // ------------------------------------------------------------------
    // configuration port, always ready
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;
    assign cfg_write   = i_cfg.valid && i_cfg.ready
                         && (i_cfg.index == mf3_pkg::REG_FRAME_WIDTH
                             || i_cfg.index == mf3_pkg::REG_FRAME_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= mf3_pkg::RESET_WIDTH;
            r_frame_height <= mf3_pkg::RESET_HEIGHT;
            r_cfg_busy     <= 1'b0;
        end else begin
            r_cfg_busy <= cfg_write;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    mf3_pkg::REG_FRAME_WIDTH: begin
                        r_frame_width <= i_cfg.data[mf3_pkg::FW_W-1:0];
                    end
                    mf3_pkg::REG_FRAME_HEIGHT: begin
                        r_frame_height <= i_cfg.data[mf3_pkg::FH_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // clamp width to 1..MAX_WIDTH and height to 1..HEIGHT_LIMIT
    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            eff_h = mf3_pkg::FH_W'(1);
        end else if (32'(r_frame_height) > 32'(mf3_pkg::HEIGHT_LIMIT)) begin
            eff_h = mf3_pkg::FH_W'(mf3_pkg::HEIGHT_LIMIT);
        end else begin
            eff_h = r_frame_height;
        end
        // final result comes with item number w*h + w of the frame
        n_last_t = LTW'(eff_w) * LTW'(eff_h) + LTW'(eff_w);
    end

    always_ff @(posedge i_clk) begin
        r_last_t <= n_last_t;
    end

    // ------------------------------------------------------------------
    // accept stage: position bookkeeping and result decisions
    // ------------------------------------------------------------------
    assign s2_ready  = !r_s2_valid || out_ready;
    assign s1_commit = r_s1_valid && s2_ready;
    assign in_ready  = (!r_s1_valid || s1_commit) && !r_cfg_busy;
    assign i_pix.ready = in_ready;
    assign in_accept = i_pix.valid && in_ready;

    always_comb begin
        px      = (i_pix.kind == mf3_pkg::KIND_FLUSH) ? '0 : i_pix.pixel_in;
        produce = 32'(r_items) >= 32'(eff_w) + 32'd1;
        last    = 32'(r_items) == 32'(r_last_t);
        wrap    = (WW'(r_col) + WW'(1)) >= eff_w;
        // center sits one row and one column back; column 0 input means the
        // center is the last column of a row, which is always border
        med_sel = (r_col >= AW'(2)) && (r_row >= mf3_pkg::FH_W'(2)) && (r_row < eff_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_items <= '0;
        end else if (cfg_write) begin
            // register write restarts the frame
            r_col   <= '0;
            r_row   <= '0;
            r_items <= '0;
        end else if (in_accept) begin
            if (produce && last) begin
                r_col   <= '0;
                r_row   <= '0;
                r_items <= '0;
            end else begin
                r_items <= r_items + mf3_pkg::ITEMS_W'(1);
                if (wrap) begin
                    r_col <= '0;
                    r_row <= r_row + mf3_pkg::FH_W'(1);
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // line buffers: read on accept, write back on commit
    // ------------------------------------------------------------------
    mf3_ram #(
        .WIDTH (mf3_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lb_upper (
        .i_clk   (i_clk),
        .i_we    (s1_commit),
        .i_waddr (r_s1_addr),
        .i_wdata (mid),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (up_rd)
    );

    mf3_ram #(
        .WIDTH (mf3_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lb_middle (
        .i_clk   (i_clk),
        .i_we    (s1_commit),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1_px),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (mid_rd)
    );

    // same-address read while the previous item writes (one-pixel rows):
    // take the data being written instead of the stale read
    assign up  = r_fwd ? r_fwd_up  : up_rd;
    assign mid = r_fwd ? r_fwd_mid : mid_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!r_s1_valid || s1_commit) begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_px   <= px;
            r_s1_addr <= r_col;
            r_s1_med  <= med_sel;
            r_s1_last <= last;
            r_s1_prod <= produce;
            r_fwd     <= s1_commit && (r_col == r_s1_addr);
            r_fwd_up  <= mid;
            r_fwd_mid <= r_s1_px;
        end
    end

    // ------------------------------------------------------------------
    // window: chain of three column cells, newest column enters cell 2
    // ------------------------------------------------------------------
    assign new_col    = mf3_pkg::make_column(up, mid, r_s1_px);
    assign cell_in[2] = new_col;
    assign cell_in[1] = cell_out[2];
    assign cell_in[0] = cell_out[1];

    for (genvar k = 0; k < 3; k++) begin : g_cell
        mf3_col_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (s1_commit),
            .i_col   (cell_in[k]),
            .o_col   (cell_out[k])
        );
    end

    mf3_median u_median (
        .i_c0     (cell_out[0]),
        .i_c1     (cell_out[1]),
        .i_c2     (cell_out[2]),
        .o_median (median)
    );

    // stage 2 only tracks items that give a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= s1_commit && r_s1_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready) begin
            r_s2_med  <= r_s1_med;
            r_s2_last <= r_s1_last;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    assign out_ready = !r_out_valid || o_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            // border pixels pass the raw center through
            r_out_pixel <= r_s2_med ? median : cell_out[1].cen;
            r_out_last  <= r_s2_last;
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_out  = r_out_pixel;
    assign o_pix.frame_last = r_out_last;

endmodule
